// ===== design/bba_pkg.sv =====
// shared constants, codes and types of the block bitmap allocator
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int MAX_WANT_DEF   = 64;

    // item and result field widths
    localparam int MODE_FW  = 3;
    localparam int IDX_FW   = 11;
    localparam int END_FW   = 11;
    localparam int WANT_FW  = 7;
    localparam int FOUND_FW = 10;
    localparam int START_W  = IDX_FW - 1;

    // bitmap word geometry
    localparam int WORD_W  = 32;
    localparam int WORD_BW = 5;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_FW-1:0] MODE_QUERY       = 3'd0;
    localparam logic [MODE_FW-1:0] MODE_FIND        = 3'd1;
    localparam logic [MODE_FW-1:0] MODE_CLAIM_ONE   = 3'd2;
    localparam logic [MODE_FW-1:0] MODE_FREE_ONE    = 3'd3;
    localparam logic [MODE_FW-1:0] MODE_CLAIM_RANGE = 3'd4;
    localparam logic [MODE_FW-1:0] MODE_FREE_RANGE  = 3'd5;

    // work orders handed from front to back
    typedef enum logic [2:0] {
        OP_NOTE,
        OP_QUERY,
        OP_FIND,
        OP_ONE,
        OP_RANGE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               value;
        logic               list_done;
        logic [START_W-1:0] start;
        logic [END_FW-1:0]  stop;
        logic [WANT_FW-1:0] want;
    } t_cmd;

    typedef struct packed {
        logic                free_flag;
        logic [FOUND_FW-1:0] found_index;
        logic                found_ok;
        logic                last;
        logic                list_done;
    } t_result;

endpackage

// ===== design/bba_ifs.sv =====
// valid/ready channel interfaces for allocator items and results
interface bba_in_if import bba_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_FW-1:0]        mode;
    logic signed [IDX_FW-1:0]  block_index;
    logic [END_FW-1:0]         range_end;
    logic [WANT_FW-1:0]        want_count;
    logic                      list_end;

    modport source (
        output valid, mode, block_index, range_end, want_count, list_end,
        input  ready
    );
    modport sink (
        input  valid, mode, block_index, range_end, want_count, list_end,
        output ready
    );
endinterface

interface bba_out_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                free_flag;
    logic [FOUND_FW-1:0] found_index;
    logic                found_ok;
    logic                last;
    logic                list_done;

    modport source (
        output valid, free_flag, found_index, found_ok, last, list_done,
        input  ready
    );
    modport sink (
        input  valid, free_flag, found_index, found_ok, last, list_done,
        output ready
    );
endinterface

// ===== design/bba_front.sv =====
// front end: accepts item beats and turns them into back-end orders
module bba_front import bba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int MAX_WANT   = MAX_WANT_DEF
) (
    bba_in_if.sink i_in,
    input  logic   i_hold,
    input  logic   i_push_ready,
    output logic   o_push_valid,
    output t_cmd   o_push_cmd
);

    localparam int LIM_W =
        (($clog2(NUM_BLOCKS + 1) > END_FW) ? $clog2(NUM_BLOCKS + 1) : END_FW) + 1;

    logic               idx_neg;
    logic [START_W-1:0] idx_mag;
    logic               in_map;
    logic [END_FW-1:0]  stop;
    logic               known;
    t_cmd               cmd;

    always_comb begin
        idx_neg = i_in.block_index[IDX_FW-1];
        idx_mag = i_in.block_index[START_W-1:0];
        in_map  = !idx_neg && (LIM_W'(idx_mag) < LIM_W'(NUM_BLOCKS));

        // range end is cut at the map size
        if (LIM_W'(i_in.range_end) > LIM_W'(NUM_BLOCKS)) begin
            stop = END_FW'(NUM_BLOCKS);
        end else begin
            stop = i_in.range_end;
        end

        known         = 1'b1;
        cmd.op        = OP_NOTE;
        cmd.value     = 1'b0;
        cmd.list_done = 1'b0;
        cmd.start     = idx_mag;
        cmd.stop      = stop;
        cmd.want      = i_in.want_count;

        case (i_in.mode)
            MODE_QUERY: begin
                if (in_map) begin
                    cmd.op = OP_QUERY;
                end
            end
            MODE_FIND: begin
                if ((i_in.want_count != '0) &&
                    (i_in.want_count <= WANT_FW'(MAX_WANT))) begin
                    cmd.op = OP_FIND;
                end
            end
            MODE_CLAIM_ONE, MODE_FREE_ONE: begin
                cmd.value     = (i_in.mode == MODE_CLAIM_ONE);
                cmd.list_done = i_in.list_end;
                if (in_map) begin
                    cmd.op = OP_ONE;
                end
            end
            MODE_CLAIM_RANGE, MODE_FREE_RANGE: begin
                cmd.value = (i_in.mode == MODE_CLAIM_RANGE);
                if (!idx_neg && ({1'b0, idx_mag} < stop)) begin
                    cmd.op = OP_RANGE;
                end
            end
            default: begin
                // unused modes are taken and dropped
                known = 1'b0;
            end
        endcase
    end

    assign i_in.ready   = !i_hold && i_push_ready;
    assign o_push_valid = i_in.valid && !i_hold && known;
    assign o_push_cmd   = cmd;

endmodule

// ===== design/bba_queue.sv =====
// short order queue between front and back ends
module bba_queue import bba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_q[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_push_cmd;
        end
    end

endmodule

// ===== design/bba_back.sv =====
// back end: bitmap memory, word scans and result register
module bba_back import bba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_cmd       i_pop_cmd,
    output logic       o_clearing,
    bba_out_if.source  o_out
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(NUM_BLOCKS);
    localparam int POS_W     = ((BIT_W > END_FW) ? BIT_W : END_FW) + 1;
    localparam int TAIL_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
    localparam int PC_W      = $clog2(WORD_W + 1);
    localparam int SUM_W     = WANT_FW + 1;
    localparam logic [WORD_W-1:0]  TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL_BITS);
    localparam logic [WADDR_W-1:0] LAST_WA   = WADDR_W'(NUM_WORDS - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_QRY   = 4'd2;
    localparam logic [3:0] S_ONE   = 4'd3;
    localparam logic [3:0] S_RNG   = 4'd4;
    localparam logic [3:0] S_CNT   = 4'd5;
    localparam logic [3:0] S_FLD   = 4'd6;
    localparam logic [3:0] S_FEM   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    function automatic logic [WADDR_W-1:0] word_of(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] s;
        s = p >> WORD_BW;
        return s[WADDR_W-1:0];
    endfunction

    // per-byte counts, then a short sum of the bytes
    function automatic logic [PC_W-1:0] count_ones(input logic [WORD_W-1:0] w);
        logic [PC_W-1:0] total;
        logic [3:0]      part;
        total = '0;
        for (int b = 0; b < WORD_W / 8; b++) begin
            part = '0;
            for (int k = 0; k < 8; k++) begin
                part = part + 4'(w[b * 8 + k]);
            end
            total = total + PC_W'(part);
        end
        return total;
    endfunction

    function automatic logic [WORD_BW-1:0] low_bit(input logic [WORD_W-1:0] w);
        logic [WORD_BW-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = WORD_BW'(i);
            end
        end
        return r;
    endfunction

    logic [WORD_W-1:0]  r_mem [NUM_WORDS];
    logic [WORD_W-1:0]  r_rdata;

    logic [3:0]         r_state,     n_state;
    logic [WADDR_W-1:0] r_wa,        n_wa;
    logic               r_value,     n_value;
    logic               r_list_done, n_list_done;
    logic [WANT_FW-1:0] r_want,      n_want;
    logic [WORD_BW-1:0] r_lo,        n_lo;
    logic [WORD_BW-1:0] r_hi,        n_hi;
    logic [WADDR_W-1:0] r_first_wa,  n_first_wa;
    logic [WADDR_W-1:0] r_last_wa,   n_last_wa;
    logic [WANT_FW-1:0] r_cnt,       n_cnt;
    logic [WORD_W-1:0]  r_free,      n_free;
    logic               r_out_valid, n_out_valid;
    t_result            r_res,       n_res;

    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;
    logic               slot;
    logic               load;
    logic [WORD_W-1:0]  free_bits;
    logic [PC_W-1:0]    pc;
    logic [SUM_W-1:0]   sum;
    logic [WORD_BW-1:0] lo;
    logic [WORD_BW-1:0] hi;
    logic [WORD_W-1:0]  rmask;
    logic [WORD_W-1:0]  bmask;
    logic [POS_W-1:0]   pos;
    logic [END_FW-1:0]  stop_m1;
    logic               fin;

    always_comb begin
        slot      = !r_out_valid || o_out.ready;
        free_bits = ~r_rdata & ((r_wa == LAST_WA) ? TAIL_MASK : {WORD_W{1'b1}});
        pc        = count_ones(free_bits);
        sum       = SUM_W'(r_cnt) + SUM_W'(pc);
        lo        = (r_wa == r_first_wa) ? r_lo : '0;
        hi        = (r_wa == r_last_wa) ? r_hi : WORD_BW'(WORD_W - 1);
        rmask     = ({WORD_W{1'b1}} << lo) &
                    ({WORD_W{1'b1}} >> (WORD_BW'(WORD_W - 1) - hi));
        bmask     = WORD_W'(1) << r_lo;
        pos       = (POS_W'(r_wa) << WORD_BW) | POS_W'(low_bit(r_free));
        stop_m1   = i_pop_cmd.stop - END_FW'(1);
        fin       = ((r_cnt + WANT_FW'(1)) == r_want);

        n_state     = r_state;
        n_wa        = r_wa;
        n_value     = r_value;
        n_list_done = r_list_done;
        n_want      = r_want;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_first_wa  = r_first_wa;
        n_last_wa   = r_last_wa;
        n_cnt       = r_cnt;
        n_free      = r_free;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_wdata   = r_rdata;
        o_pop_ready = 1'b0;
        load        = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_wa == LAST_WA) begin
                    n_wa    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_wa = r_wa + WADDR_W'(1);
                end
            end
            S_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_value     = i_pop_cmd.value;
                    n_list_done = i_pop_cmd.list_done;
                    n_want      = i_pop_cmd.want;
                    n_lo        = i_pop_cmd.start[WORD_BW-1:0];
                    n_hi        = stop_m1[WORD_BW-1:0];
                    n_first_wa  = word_of(POS_W'(i_pop_cmd.start));
                    n_last_wa   = word_of(POS_W'(stop_m1));
                    n_cnt       = '0;
                    case (i_pop_cmd.op)
                        OP_QUERY: begin
                            n_wa    = word_of(POS_W'(i_pop_cmd.start));
                            n_state = S_QRY;
                        end
                        OP_ONE: begin
                            n_wa    = word_of(POS_W'(i_pop_cmd.start));
                            n_state = S_ONE;
                        end
                        OP_RANGE: begin
                            n_wa    = word_of(POS_W'(i_pop_cmd.start));
                            n_state = S_RNG;
                        end
                        OP_FIND: begin
                            n_wa    = '0;
                            n_state = S_CNT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_QRY: begin
                if (slot) begin
                    load            = 1'b1;
                    n_res           = '0;
                    n_res.free_flag = ~r_rdata[r_lo];
                    n_res.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ONE: begin
                mem_we    = 1'b1;
                mem_wdata = r_value ? (r_rdata | bmask) : (r_rdata & ~bmask);
                n_state   = S_EMIT;
            end
            S_RNG: begin
                // write this word while the next one is read
                mem_we    = 1'b1;
                mem_wdata = r_value ? (r_rdata | rmask) : (r_rdata & ~rmask);
                if (r_wa == r_last_wa) begin
                    n_state = S_EMIT;
                end else begin
                    n_wa = r_wa + WADDR_W'(1);
                end
            end
            S_CNT: begin
                // counting pass: enough free blocks before any index goes out
                if (sum >= {1'b0, r_want}) begin
                    n_wa    = '0;
                    n_cnt   = '0;
                    n_state = S_FLD;
                end else if (r_wa == LAST_WA) begin
                    n_state = S_EMIT;
                end else begin
                    n_wa  = r_wa + WADDR_W'(1);
                    n_cnt = sum[WANT_FW-1:0];
                end
            end
            S_FLD: begin
                n_free  = free_bits;
                n_state = S_FEM;
            end
            S_FEM: begin
                if (r_free == '0) begin
                    n_wa    = r_wa + WADDR_W'(1);
                    n_state = S_FLD;
                end else if (slot) begin
                    load              = 1'b1;
                    n_res             = '0;
                    n_res.found_index = pos[FOUND_FW-1:0];
                    n_res.found_ok    = 1'b1;
                    n_res.last        = fin;
                    n_free            = r_free & (r_free - WORD_W'(1));
                    n_cnt             = r_cnt + WANT_FW'(1);
                    if (fin) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (slot) begin
                    load            = 1'b1;
                    n_res           = '0;
                    n_res.list_done = r_list_done;
                    n_res.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wa        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wa        <= n_wa;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_list_done <= n_list_done;
        r_want      <= n_want;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_first_wa  <= n_first_wa;
        r_last_wa   <= n_last_wa;
        r_cnt       <= n_cnt;
        r_free      <= n_free;
        r_res       <= n_res;
    end

    // bitmap words: write at the current word, read the next word's address
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wa] <= mem_wdata;
        end
        r_rdata <= r_mem[n_wa];
    end

    assign o_clearing        = (r_state == S_CLEAR);
    assign o_out.valid       = r_out_valid;
    assign o_out.free_flag   = r_res.free_flag;
    assign o_out.found_index = r_res.found_index;
    assign o_out.found_ok    = r_res.found_ok;
    assign o_out.last        = r_res.last;
    assign o_out.list_done   = r_res.list_done;

endmodule

// ===== design/block_bitmap_allocator_core.sv =====
// top level of the first-fit block bitmap allocator
//
//   port     dir   modport  beat
//   i_in     in    sink     mode, block_index, range_end, want_count, list_end
//   o_out    out   source   free_flag, found_index, found_ok, last, list_done
//
// query and claim/free one touch a single word; a range order writes the bitmap per 32-bit word
// find: a counting pass over the words, then a scan that emits the first free indices
// after reset a clearing pass zeroes every bitmap word (32 words by default)
// with i_in held off; a two-entry order queue lets the front take beats while the
// back scans, and a stalled o_out holds the back end, then i_in once the queue fills
module block_bitmap_allocator_core import bba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int MAX_WANT   = MAX_WANT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_in_if.sink     i_in,
    bba_out_if.source  o_out
);

    logic push_valid;
    logic push_ready;
    t_cmd push_cmd;
    logic pop_valid;
    logic pop_ready;
    t_cmd pop_cmd;
    logic clearing;

    bba_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_WANT   (MAX_WANT)
    ) u_front (
        .i_in         (i_in),
        .i_hold       (clearing),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    bba_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    bba_back #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_cmd   (pop_cmd),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule
